FILE: design/wheel_encoder_drive_controller_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the wheel encoder drive controller
// Checks use the module's clk_i and rst_ni; define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef WHEEL_ENCODER_DRIVE_CONTROLLER_MACROS_SVH
`define WHEEL_ENCODER_DRIVE_CONTROLLER_MACROS_SVH

`ifndef ASSERT_OFF
// A property that must hold on every clock edge outside reset.
`define ASSERT_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// When pre holds, post must hold on the next clock.
`define ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define ASSERT_CHK(lbl, prop, msg)
`define ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

FILE: design/wedc_pkg.sv
// ----------------------------------------------------------------------------
// wedc_pkg
// Shared constants, types and duty helpers of the wheel encoder controller.
// ----------------------------------------------------------------------------
package wedc_pkg;

  localparam int COUNT_WIDTH  = 16;
  localparam int TIME_WIDTH   = 32;
  localparam int RPM_WIDTH    = 16;
  localparam int DUTY_WIDTH   = 8;
  localparam int SPEED_WIDTH  = 9;
  localparam int TARGET_WIDTH = 15;
  localparam int PPR_WIDTH    = 8;
  localparam int PROD_WIDTH   = TIME_WIDTH + PPR_WIDTH;
  localparam int BIT_CNT_W    = $clog2(RPM_WIDTH);
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [PPR_WIDTH-1:0]  PPR_RESET     = PPR_WIDTH'(20);
  localparam logic [RPM_WIDTH-1:0]  RPM_NUMERATOR = RPM_WIDTH'(60000);
  localparam logic [DUTY_WIDTH-1:0] FULL_DUTY     = DUTY_WIDTH'(255);

  typedef enum logic [1:0] {
    CMD_DRIVE       = 2'd0,
    CMD_MOVE        = 2'd1,
    CMD_LEFT_PULSE  = 2'd2,
    CMD_RIGHT_PULSE = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    OP_DRIVE = 2'd0,
    OP_MOVE  = 2'd1,
    OP_PULSE = 2'd2
  } op_e;

  localparam logic WHEEL_LEFT  = 1'b0;
  localparam logic WHEEL_RIGHT = 1'b1;

  typedef struct packed {
    op_e                              op;
    logic                             wheel;
    logic signed [SPEED_WIDTH-1:0]    left_speed;
    logic signed [SPEED_WIDTH-1:0]    right_speed;
    logic [TARGET_WIDTH-1:0]          left_target;
    logic [TARGET_WIDTH-1:0]          right_target;
    logic [TIME_WIDTH-1:0]            now_ms;
  } item_t;

  typedef struct packed {
    logic [DUTY_WIDTH-1:0] left_duty_a;
    logic [DUTY_WIDTH-1:0] left_duty_b;
    logic [DUTY_WIDTH-1:0] right_duty_a;
    logic [DUTY_WIDTH-1:0] right_duty_b;
    logic [RPM_WIDTH-1:0]  left_rpm;
    logic [RPM_WIDTH-1:0]  right_rpm;
    logic [15:0]           left_pulses;
    logic [15:0]           right_pulses;
    logic                  in_position_mode;
  } result_t;

  // Forward speed drives bridge input A.
  function automatic logic [DUTY_WIDTH-1:0] duty_a(logic signed [SPEED_WIDTH-1:0] speed);
    logic [DUTY_WIDTH-1:0] d;
    d = '0;
    if (speed > 0) begin
      d = speed[DUTY_WIDTH-1:0];
    end
    return d;
  endfunction

  // Zero or reverse speed drives bridge input B with the magnitude, clipped to full duty.
  function automatic logic [DUTY_WIDTH-1:0] duty_b(logic signed [SPEED_WIDTH-1:0] speed);
    logic signed [SPEED_WIDTH:0] mag;
    logic [DUTY_WIDTH-1:0]       d;
    mag = -((SPEED_WIDTH+1)'(speed));
    d   = '0;
    if (!(speed > 0)) begin
      if (mag > (SPEED_WIDTH+1)'(FULL_DUTY)) begin
        d = FULL_DUTY;
      end else begin
        d = mag[DUTY_WIDTH-1:0];
      end
    end
    return d;
  endfunction

endpackage

FILE: design/wedc_fifo.sv
// ----------------------------------------------------------------------------
// wedc_fifo
// Short queue of decoded words between the front decoder and the back end.
// ----------------------------------------------------------------------------
`include "wheel_encoder_drive_controller_macros.svh"

module wedc_fifo import wedc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  input  logic  pop_i,
  output item_t pop_item_o,
  output logic  full_o,
  output logic  empty_o
);

  item_t              mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_q, rd_q;
  logic [FIFO_AW:0]   cnt_q;

  assign full_o     = (cnt_q == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= wr_q + FIFO_AW'(1);
      end
      if (pop_i) begin
        rd_q <= rd_q + FIFO_AW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + (FIFO_AW+1)'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - (FIFO_AW+1)'(1);
      end
    end
  end

  `ASSERT_CHK(a_no_overflow, push_i |-> !full_o, "word pushed into a full queue")
  `ASSERT_CHK(a_no_underflow, pop_i |-> !empty_o, "word popped from an empty queue")
  `ASSERT_NEXT(a_count_up, push_i && !pop_i, cnt_q == $past(cnt_q) + 1'b1, "fill count lost a push")

endmodule

FILE: design/wedc_front.sv
// ----------------------------------------------------------------------------
// wedc_front
// Accepts input words and decodes the command into an operation and wheel.
// ----------------------------------------------------------------------------
module wedc_front import wedc_pkg::*; (
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     command_i,
  input  logic signed [SPEED_WIDTH-1:0]  left_speed_i,
  input  logic signed [SPEED_WIDTH-1:0]  right_speed_i,
  input  logic [TARGET_WIDTH-1:0]        left_target_i,
  input  logic [TARGET_WIDTH-1:0]        right_target_i,
  input  logic [31:0]                    now_ms_i,
  input  logic                           fifo_full_i,
  output logic                           push_o,
  output item_t                          push_item_o
);

  assign in_stall_o = fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    push_item_o              = '0;
    push_item_o.left_speed   = left_speed_i;
    push_item_o.right_speed  = right_speed_i;
    push_item_o.left_target  = left_target_i;
    push_item_o.right_target = right_target_i;
    push_item_o.now_ms       = TIME_WIDTH'(now_ms_i);
    case (cmd_e'(command_i))
      CMD_DRIVE: begin
        push_item_o.op    = OP_DRIVE;
        push_item_o.wheel = WHEEL_LEFT;
      end
      CMD_MOVE: begin
        push_item_o.op    = OP_MOVE;
        push_item_o.wheel = WHEEL_LEFT;
      end
      CMD_LEFT_PULSE: begin
        push_item_o.op    = OP_PULSE;
        push_item_o.wheel = WHEEL_LEFT;
      end
      CMD_RIGHT_PULSE: begin
        push_item_o.op    = OP_PULSE;
        push_item_o.wheel = WHEEL_RIGHT;
      end
      default: begin
        push_item_o.op    = OP_DRIVE;
        push_item_o.wheel = WHEEL_LEFT;
      end
    endcase
  end

endmodule

FILE: design/wedc_back.sv
// ----------------------------------------------------------------------------
// wedc_back
// Executes decoded words: drive state, pulse counts and a serial RPM divider.
// ----------------------------------------------------------------------------
`include "wheel_encoder_drive_controller_macros.svh"

module wedc_back import wedc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  input  logic [PPR_WIDTH-1:0] cfg_data_i,
  output logic                 cfg_ready_o,
  input  logic                 fifo_empty_i,
  input  item_t                fifo_item_i,
  output logic                 fifo_pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output result_t              result_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                  st_q, st_d;
  item_t                   cur_q;
  logic [PPR_WIDTH-1:0]    ppr_q;
  logic [PROD_WIDTH-1:0]   prod_q;
  logic [RPM_WIDTH:0]      rem_q;
  logic [RPM_WIDTH-1:0]    quo_q;
  logic [BIT_CNT_W-1:0]    bit_q;

  logic signed [SPEED_WIDTH-1:0] drive_q [2];
  logic signed [SPEED_WIDTH-1:0] drive_d [2];
  logic [COUNT_WIDTH-1:0]        count_q [2];
  logic [COUNT_WIDTH-1:0]        count_d [2];
  logic [TARGET_WIDTH-1:0]       goal_q  [2];
  logic [TARGET_WIDTH-1:0]       goal_d  [2];
  logic [TIME_WIDTH-1:0]         last_q  [2];
  logic [TIME_WIDTH-1:0]         last_d  [2];
  logic [RPM_WIDTH-1:0]          rpm_q   [2];
  logic [RPM_WIDTH-1:0]          rpm_d   [2];
  logic                          pos_q, pos_d;

  logic                  out_valid_q;
  result_t               res_q, res_d;
  logic                  out_free, apply;
  logic [TIME_WIDTH-1:0] elapsed;
  logic [RPM_WIDTH:0]    rem_sh;
  logic                  rem_ge;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic [RPM_WIDTH-1:0]  rpm_val;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign apply       = (st_q == ST_DONE) && out_free;
  assign fifo_pop_o  = (st_q == ST_IDLE) && !fifo_empty_i;
  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  // Time since this wheel's previous pulse, wrapping with the timestamp.
  assign elapsed = cur_q.now_ms - last_q[cur_q.wheel];

  // Restoring division of the RPM numerator, one quotient bit per cycle.
  assign rem_sh  = {rem_q[RPM_WIDTH-1:0], RPM_NUMERATOR[bit_q]};
  assign rem_ge  = PROD_WIDTH'(rem_sh) >= prod_q;
  assign rpm_val = (prod_q == '0) ? RPM_NUMERATOR : quo_q;
  assign cnt_inc = count_q[cur_q.wheel] + COUNT_WIDTH'(1);

  always_comb begin
    st_d = st_q;
    case (st_q)
      ST_IDLE: begin
        if (!fifo_empty_i) begin
          st_d = (fifo_item_i.op == OP_PULSE) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  st_d = ST_DIV;
      ST_DIV: begin
        if (bit_q == '0) begin
          st_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_comb begin
    drive_d = drive_q;
    count_d = count_q;
    goal_d  = goal_q;
    last_d  = last_q;
    rpm_d   = rpm_q;
    pos_d   = pos_q;
    if (apply) begin
      case (cur_q.op)
        OP_DRIVE: begin
          drive_d[0] = cur_q.left_speed;
          drive_d[1] = cur_q.right_speed;
          pos_d      = 1'b0;
        end
        OP_MOVE: begin
          count_d[0] = '0;
          count_d[1] = '0;
          goal_d[0]  = cur_q.left_target;
          goal_d[1]  = cur_q.right_target;
          drive_d[0] = SPEED_WIDTH'(FULL_DUTY);
          drive_d[1] = SPEED_WIDTH'(FULL_DUTY);
          pos_d      = 1'b1;
        end
        OP_PULSE: begin
          rpm_d[cur_q.wheel]   = rpm_val;
          last_d[cur_q.wheel]  = cur_q.now_ms;
          count_d[cur_q.wheel] = cnt_inc;
          if (pos_q && (32'(cnt_inc) >= 32'(goal_q[cur_q.wheel]))) begin
            drive_d[cur_q.wheel] = '0;
          end
        end
        default: begin
          pos_d = pos_q;
        end
      endcase
    end
  end

  always_comb begin
    res_d.left_duty_a      = duty_a(drive_d[0]);
    res_d.left_duty_b      = duty_b(drive_d[0]);
    res_d.right_duty_a     = duty_a(drive_d[1]);
    res_d.right_duty_b     = duty_b(drive_d[1]);
    res_d.left_rpm         = rpm_d[0];
    res_d.right_rpm        = rpm_d[1];
    res_d.left_pulses      = 16'(count_d[0]);
    res_d.right_pulses     = 16'(count_d[1]);
    res_d.in_position_mode = pos_d;
  end

  // Datapath registers of the current word and the divider.
  always_ff @(posedge clk_i) begin
    if (fifo_pop_o) begin
      cur_q <= fifo_item_i;
    end
    if (st_q == ST_MUL) begin
      prod_q <= PROD_WIDTH'(elapsed) * PROD_WIDTH'(ppr_q);
      rem_q  <= '0;
      quo_q  <= '0;
      bit_q  <= BIT_CNT_W'(RPM_WIDTH - 1);
    end else if (st_q == ST_DIV) begin
      rem_q        <= rem_ge ? (rem_sh - (RPM_WIDTH+1)'(prod_q)) : rem_sh;
      quo_q[bit_q] <= rem_ge;
      bit_q        <= bit_q - BIT_CNT_W'(1);
    end
    if (apply) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      ppr_q       <= PPR_RESET;
      pos_q       <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 2; i++) begin
        drive_q[i] <= '0;
        count_q[i] <= '0;
        goal_q[i]  <= '0;
        last_q[i]  <= '0;
        rpm_q[i]   <= '0;
      end
    end else begin
      st_q    <= st_d;
      pos_q   <= pos_d;
      drive_q <= drive_d;
      count_q <= count_d;
      goal_q  <= goal_d;
      last_q  <= last_d;
      rpm_q   <= rpm_d;
      if (cfg_valid_i) begin
        ppr_q <= cfg_data_i;
      end
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  `ASSERT_NEXT(a_mul_to_div, st_q == ST_MUL, st_q == ST_DIV, "multiply not followed by divide")
  `ASSERT_NEXT(a_div_ends, (st_q == ST_DIV) && (bit_q == '0), st_q == ST_DONE, "divider overran")
  `ASSERT_CHK(a_out_from_done, $rose(out_valid_q) |-> $past(st_q == ST_DONE), "result outside done")

endmodule

FILE: design/wheel_encoder_drive_controller.sv
// ----------------------------------------------------------------------------
// wheel_encoder_drive_controller
// Two-wheel H-bridge drive with encoder pulse counting and RPM measurement.
//
// Input words arrive on in_valid_i / in_stall_o and are accepted when valid is
// high and stall is low. Each word carries a command: drive speeds, move to
// target counts, or a left or right encoder pulse with its millisecond time.
// Every accepted word yields exactly one result word on out_valid_o /
// out_stall_i with both wheels' duties, RPM, pulse counts and position mode.
// A front decoder places words in a four-deep queue; the back end pops one at
// a time and pops the next only after the current result has been registered.
// A drive or move word goes from idle straight to the done state. A pulse
// word first passes the multiply state and then the 16-step serial divider
// that forms 60000 / (elapsed ms * pulses per rev).
// The pulses-per-rev register is written on cfg_valid_i (cfg_ready_o is
// always high); the user must write it only while the block is idle, as the
// block itself does not enforce this. Reset clears all wheel state and
// loads 20 pulses per revolution. When the receiver stalls the result is
// held, the back end waits, and the queue fills before in_stall_o rises.
// ----------------------------------------------------------------------------
module wheel_encoder_drive_controller import wedc_pkg::*; (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [PPR_WIDTH-1:0]          cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic signed [SPEED_WIDTH-1:0] left_speed_i,
  input  logic signed [SPEED_WIDTH-1:0] right_speed_i,
  input  logic [TARGET_WIDTH-1:0]       left_target_i,
  input  logic [TARGET_WIDTH-1:0]       right_target_i,
  input  logic [31:0]                   now_ms_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [DUTY_WIDTH-1:0]         left_duty_a_o,
  output logic [DUTY_WIDTH-1:0]         left_duty_b_o,
  output logic [DUTY_WIDTH-1:0]         right_duty_a_o,
  output logic [DUTY_WIDTH-1:0]         right_duty_b_o,
  output logic [RPM_WIDTH-1:0]          left_rpm_o,
  output logic [RPM_WIDTH-1:0]          right_rpm_o,
  output logic [15:0]                   left_pulses_o,
  output logic [15:0]                   right_pulses_o,
  output logic                          in_position_mode_o
);

  // Decoded words travel from the front decoder through the queue.
  logic    push, pop, full, empty;
  item_t   push_item, pop_item;
  result_t result;

  wedc_front u_front (
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .command_i      (command_i),
    .left_speed_i   (left_speed_i),
    .right_speed_i  (right_speed_i),
    .left_target_i  (left_target_i),
    .right_target_i (right_target_i),
    .now_ms_i       (now_ms_i),
    .fifo_full_i    (full),
    .push_o         (push),
    .push_item_o    (push_item)
  );

  wedc_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .full_o      (full),
    .empty_o     (empty)
  );

  // The back end holds all wheel state and the registered result word.
  wedc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .cfg_ready_o  (cfg_ready_o),
    .fifo_empty_i (empty),
    .fifo_item_i  (pop_item),
    .fifo_pop_o   (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_o     (result)
  );

  assign left_duty_a_o      = result.left_duty_a;
  assign left_duty_b_o      = result.left_duty_b;
  assign right_duty_a_o     = result.right_duty_a;
  assign right_duty_b_o     = result.right_duty_b;
  assign left_rpm_o         = result.left_rpm;
  assign right_rpm_o        = result.right_rpm;
  assign left_pulses_o      = result.left_pulses;
  assign right_pulses_o     = result.right_pulses;
  assign in_position_mode_o = result.in_position_mode;

endmodule

FILE: bench/wheel_encoder_drive_controller_test.sv
// ----------------------------------------------------------------------------
// Wheel encoder drive controller regression
// Drives command words through the valid/stall input channel and scores every
// status word on the output channel against a behavioural model of both
// wheels or a hand-typed word. The run covers a directed sweep, a pulse burst
// that stops a wheel at its target, and several random phases at different
// pulses-per-rev settings, with random idling and back-pressure on both sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module wheel_encoder_drive_controller_test;
  import wedc_pkg::*;

  // Run-length guard. The slowest correct run is about 1450 words, each slowed
  // by a full sender gap, a full receiver stall and the divider, plus the long
  // hold-off and the settling pauses; the limit is several times that.
  localparam int CYCLE_LIMIT   = 400_000;
  localparam int LONG_HOLD     = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASE_WORDS   = 204;
  localparam int BURST_PULSES  = 200;
  localparam int BURST_TARGET  = 100;
  localparam int MAX_REPORTS   = 10;

  // One command word as it travels on the input channel.
  typedef struct {
    cmd_e                          cmd;
    logic signed [SPEED_WIDTH-1:0] left_speed;
    logic signed [SPEED_WIDTH-1:0] right_speed;
    logic [TARGET_WIDTH-1:0]       left_target;
    logic [TARGET_WIDTH-1:0]       right_target;
    logic [TIME_WIDTH-1:0]         now_ms;
  } command_word_t;

  // A row of the directed sweep. Where known is set, the status word is
  // typed in by hand rather than taken from the wheel model.
  typedef struct {
    command_word_t word;
    bit            known;
    result_t       want;
  } sweep_row_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [PPR_WIDTH-1:0]          cfg_data_i;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [1:0]                    command_i;
  logic signed [SPEED_WIDTH-1:0] left_speed_i;
  logic signed [SPEED_WIDTH-1:0] right_speed_i;
  logic [TARGET_WIDTH-1:0]       left_target_i;
  logic [TARGET_WIDTH-1:0]       right_target_i;
  logic [31:0]                   now_ms_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [DUTY_WIDTH-1:0]         left_duty_a_o;
  logic [DUTY_WIDTH-1:0]         left_duty_b_o;
  logic [DUTY_WIDTH-1:0]         right_duty_a_o;
  logic [DUTY_WIDTH-1:0]         right_duty_b_o;
  logic [RPM_WIDTH-1:0]          left_rpm_o;
  logic [RPM_WIDTH-1:0]          right_rpm_o;
  logic [15:0]                   left_pulses_o;
  logic [15:0]                   right_pulses_o;
  logic                          in_position_mode_o;

  wheel_encoder_drive_controller dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_valid_i        (cfg_valid_i),
    .cfg_ready_o        (cfg_ready_o),
    .cfg_data_i         (cfg_data_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .command_i          (command_i),
    .left_speed_i       (left_speed_i),
    .right_speed_i      (right_speed_i),
    .left_target_i      (left_target_i),
    .right_target_i     (right_target_i),
    .now_ms_i           (now_ms_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .left_duty_a_o      (left_duty_a_o),
    .left_duty_b_o      (left_duty_b_o),
    .right_duty_a_o     (right_duty_a_o),
    .right_duty_b_o     (right_duty_b_o),
    .left_rpm_o         (left_rpm_o),
    .right_rpm_o        (right_rpm_o),
    .left_pulses_o      (left_pulses_o),
    .right_pulses_o     (right_pulses_o),
    .in_position_mode_o (in_position_mode_o)
  );

  // --------------------------------------------------------------------------
  // Wheel model state. It mirrors what the block should hold after every
  // accepted word, including the pulses-per-rev register.
  // --------------------------------------------------------------------------
  logic signed [SPEED_WIDTH-1:0] left_drive, right_drive;
  logic [COUNT_WIDTH-1:0]        left_count, right_count;
  logic [TARGET_WIDTH-1:0]       left_goal, right_goal;
  logic [TIME_WIDTH-1:0]         left_last_ms, right_last_ms;
  logic [RPM_WIDTH-1:0]          left_rpm_now, right_rpm_now;
  logic                          position_mode;
  logic [PPR_WIDTH-1:0]          pulses_per_rev;

  // Status words owed by the block, oldest first.
  result_t    status_due[$];
  sweep_row_t sweep_rows[$];

  int          fault_count  = 0;
  int          reports      = 0;
  int          cycle_count  = 0;
  int          stall_budget = 0;
  bit          long_hold_req = 1'b0;
  bit          idle_on       = 1'b0;
  logic [31:0] time_base     = '0;

  // --------------------------------------------------------------------------
  // Clock, 2 ns period.
  // --------------------------------------------------------------------------
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Forward speed goes to bridge input A; it can never exceed full duty.
  function automatic logic [DUTY_WIDTH-1:0] forward_duty(logic signed [SPEED_WIDTH-1:0] s);
    return (s > 0) ? s[DUTY_WIDTH-1:0] : '0;
  endfunction

  // Zero or reverse speed goes to bridge input B as a magnitude. The most
  // negative speed has a magnitude of 256, which is clipped to full duty.
  function automatic logic [DUTY_WIDTH-1:0] reverse_duty(logic signed [SPEED_WIDTH-1:0] s);
    int mag;
    mag = -int'(s);
    if (s > 0) return '0;
    if (mag > int'(FULL_DUTY)) return FULL_DUTY;
    return mag[DUTY_WIDTH-1:0];
  endfunction

  // RPM from the time since the wheel's previous pulse. The elapsed time
  // wraps with the timestamp, and a zero product saturates to the numerator.
  function automatic logic [RPM_WIDTH-1:0] rpm_from(logic [TIME_WIDTH-1:0] now,
                                                    logic [TIME_WIDTH-1:0] last);
    logic [TIME_WIDTH-1:0] elapsed;
    logic [63:0]           product;
    elapsed = now - last;
    product = 64'(elapsed) * 64'(pulses_per_rev);
    if (product == 64'd0) return RPM_NUMERATOR;
    return RPM_WIDTH'(64'(RPM_NUMERATOR) / product);
  endfunction

  // Advances the wheel model by one word and returns the status word that
  // the block should report for it.
  function automatic result_t apply_command(command_word_t w);
    result_t r;
    case (w.cmd)
      CMD_DRIVE: begin
        left_drive    = w.left_speed;
        right_drive   = w.right_speed;
        position_mode = 1'b0;
      end
      CMD_MOVE: begin
        left_count    = '0;
        right_count   = '0;
        left_goal     = w.left_target;
        right_goal    = w.right_target;
        left_drive    = {1'b0, FULL_DUTY};
        right_drive   = {1'b0, FULL_DUTY};
        position_mode = 1'b1;
      end
      CMD_LEFT_PULSE: begin
        left_rpm_now = rpm_from(w.now_ms, left_last_ms);
        left_last_ms = w.now_ms;
        left_count   = left_count + 1'b1;
        if (position_mode && left_count >= COUNT_WIDTH'(left_goal)) left_drive = '0;
      end
      default: begin
        right_rpm_now = rpm_from(w.now_ms, right_last_ms);
        right_last_ms = w.now_ms;
        right_count   = right_count + 1'b1;
        if (position_mode && right_count >= COUNT_WIDTH'(right_goal)) right_drive = '0;
      end
    endcase
    r.left_duty_a      = forward_duty(left_drive);
    r.left_duty_b      = reverse_duty(left_drive);
    r.right_duty_a     = forward_duty(right_drive);
    r.right_duty_b     = reverse_duty(right_drive);
    r.left_rpm         = left_rpm_now;
    r.right_rpm        = right_rpm_now;
    r.left_pulses      = left_count[15:0];
    r.right_pulses     = right_count[15:0];
    r.in_position_mode = position_mode;
    return r;
  endfunction

  // Builds a hand-written status word for the directed sweep.
  function automatic result_t bridge_status(int la, int lb, int ra, int rb, int lrpm,
                                            int rrpm, int lp, int rp, bit pm);
    result_t r;
    r.left_duty_a      = DUTY_WIDTH'(la);
    r.left_duty_b      = DUTY_WIDTH'(lb);
    r.right_duty_a     = DUTY_WIDTH'(ra);
    r.right_duty_b     = DUTY_WIDTH'(rb);
    r.left_rpm         = RPM_WIDTH'(lrpm);
    r.right_rpm        = RPM_WIDTH'(rrpm);
    r.left_pulses      = 16'(lp);
    r.right_pulses     = 16'(rp);
    r.in_position_mode = pm;
    return r;
  endfunction

  function automatic command_word_t make_word(cmd_e c, int ls, int rs, int lt, int rt,
                                              logic [31:0] now);
    command_word_t w;
    w.cmd          = c;
    w.left_speed   = SPEED_WIDTH'(ls);
    w.right_speed  = SPEED_WIDTH'(rs);
    w.left_target  = TARGET_WIDTH'(lt);
    w.right_target = TARGET_WIDTH'(rt);
    w.now_ms       = now;
    return w;
  endfunction

  task automatic add_row(command_word_t w, bit known, result_t want);
    sweep_row_t row;
    row.word  = w;
    row.known = known;
    row.want  = want;
    sweep_rows.push_back(row);
  endtask

  // Speeds are mostly uniform over the 9-bit range, with the edges favoured.
  function automatic logic signed [SPEED_WIDTH-1:0] random_speed();
    case ($urandom_range(0, 15))
      0:       return -9'sd256;
      1:       return -9'sd255;
      2:       return 9'sd255;
      3:       return 9'sd0;
      default: return SPEED_WIDTH'($urandom_range(0, 511));
    endcase
  endfunction

  // Small targets let the wheels reach them and stop; a few span the range.
  function automatic logic [TARGET_WIDTH-1:0] random_target();
    if ($urandom_range(0, 9) < 7) return TARGET_WIDTH'($urandom_range(0, 12));
    return TARGET_WIDTH'($urandom_range(0, 32767));
  endfunction

  // Random word. Pulses carry a mostly rising timestamp, with repeats, jumps
  // to any value and stretches just below the wrap point mixed in. Unused
  // fields always carry random content.
  function automatic command_word_t random_word();
    command_word_t w;
    int            pick;
    int            step;
    pick = $urandom_range(0, 99);
    step = $urandom_range(0, 99);
    w.left_speed   = random_speed();
    w.right_speed  = random_speed();
    w.left_target  = random_target();
    w.right_target = random_target();
    w.now_ms       = $urandom;
    if (pick < 15) begin
      w.cmd = CMD_DRIVE;
    end else if (pick < 25) begin
      w.cmd = CMD_MOVE;
    end else begin
      w.cmd = (pick < 62) ? CMD_LEFT_PULSE : CMD_RIGHT_PULSE;
      if (step < 4) begin
        time_base = $urandom;
      end else if (step < 8) begin
        time_base = 32'hFFFF_FFFF - 32'($urandom_range(0, 30));
      end else if (step >= 14) begin
        time_base = time_base + 32'($urandom_range(1, 60));
      end
      w.now_ms = time_base;
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Input channel. A word goes out on a falling edge after the drawn gap and
  // stays put until a rising edge sees valid high and stall low. With no gap
  // valid simply stays high into the next word.
  // --------------------------------------------------------------------------
  task automatic push_word(command_word_t w, bit known, result_t want);
    int      gap;
    result_t modelled;
    gap = idle_on ? $urandom_range(0, 8) : 0;
    repeat (gap) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i     <= 1'b1;
    command_i      <= w.cmd;
    left_speed_i   <= w.left_speed;
    right_speed_i  <= w.right_speed;
    left_target_i  <= w.left_target;
    right_target_i <= w.right_target;
    now_ms_i       <= w.now_ms;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    // The model always advances; a hand-typed status replaces its output.
    modelled = apply_command(w);
    status_due.push_back(known ? want : modelled);
  endtask

  // Stops offering words and waits until every owed status word has come,
  // then waits out a settling pause so that the pipeline goes quiet.
  task automatic settle_block();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes pulses-per-rev; only called while the block is quiet.
  task automatic write_ppr(logic [PPR_WIDTH-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    pulses_per_rev = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Output channel. The stall line is driven on falling edges: a long
  // hold-off when one is asked for, counted here, otherwise the per-word
  // stall drawn when the previous status word was taken.
  // --------------------------------------------------------------------------
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      if (stall_budget > 0) begin
        stall_budget = stall_budget - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fault_count = fault_count + 1;
      if (reports < MAX_REPORTS) begin
        reports = reports + 1;
        $display("mismatch on %s at cycle %0d: expected %0d, got %0d",
                 name, cycle_count, want, got);
      end
    end
  endtask

  // Every status word taken from the block is scored, field by field,
  // against the oldest word still owed.
  always @(posedge clk_i) begin : score_status
    result_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      stall_budget = idle_on ? $urandom_range(0, 8) : 0;
      if (status_due.size() == 0) begin
        fault_count = fault_count + 1;
        if (reports < MAX_REPORTS) begin
          reports = reports + 1;
          $display("status word at cycle %0d with nothing owed", cycle_count);
        end
      end else begin
        want = status_due.pop_front();
        report_field("left_duty_a", 32'(want.left_duty_a), 32'(left_duty_a_o));
        report_field("left_duty_b", 32'(want.left_duty_b), 32'(left_duty_b_o));
        report_field("right_duty_a", 32'(want.right_duty_a), 32'(right_duty_a_o));
        report_field("right_duty_b", 32'(want.right_duty_b), 32'(right_duty_b_o));
        report_field("left_rpm", 32'(want.left_rpm), 32'(left_rpm_o));
        report_field("right_rpm", 32'(want.right_rpm), 32'(right_rpm_o));
        report_field("left_pulses", 32'(want.left_pulses), 32'(left_pulses_o));
        report_field("right_pulses", 32'(want.right_pulses), 32'(right_pulses_o));
        report_field("in_position_mode", 32'(want.in_position_mode),
                     32'(in_position_mode_o));
      end
    end
  end

  // Hard stop should the block hang.
  always @(posedge clk_i) begin
    cycle_count = cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int                   phase;
    int                   n;
    logic [PPR_WIDTH-1:0] ppr;
    logic [31:0]          now;

    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    command_i      = CMD_DRIVE;
    left_speed_i   = '0;
    right_speed_i  = '0;
    left_target_i  = '0;
    right_target_i = '0;
    now_ms_i       = '0;

    left_drive     = '0;
    right_drive    = '0;
    left_count     = '0;
    right_count    = '0;
    left_goal      = '0;
    right_goal     = '0;
    left_last_ms   = '0;
    right_last_ms  = '0;
    left_rpm_now   = '0;
    right_rpm_now  = '0;
    position_mode  = 1'b0;
    pulses_per_rev = PPR_RESET;

    // Directed sweep, run at the reset value of 20 pulses per revolution.
    // Full speed both ways, then the most negative speed, which clips to
    // full duty on B, and the smallest speeds either side of zero.
    add_row(make_word(CMD_DRIVE, 255, -255, 0, 0, 0), 1'b1,
            bridge_status(255, 0, 0, 255, 0, 0, 0, 0, 0));
    add_row(make_word(CMD_DRIVE, -256, 0, 32767, 32767, 32'hFFFF_FFFF), 1'b1,
            bridge_status(0, 255, 0, 0, 0, 0, 0, 0, 0));
    add_row(make_word(CMD_DRIVE, 1, -1, 0, 0, 0), 1'b1,
            bridge_status(1, 0, 0, 1, 0, 0, 0, 0, 0));
    // The first pulse measures from time zero, so a stamp of zero gives a
    // zero divisor; a repeated stamp does the same.
    add_row(make_word(CMD_LEFT_PULSE, 0, 0, 0, 0, 0), 1'b1,
            bridge_status(1, 0, 0, 1, 60000, 0, 1, 0, 0));
    add_row(make_word(CMD_LEFT_PULSE, -256, 255, 32767, 0, 0), 1'b1,
            bridge_status(1, 0, 0, 1, 60000, 0, 2, 0, 0));
    add_row(make_word(CMD_LEFT_PULSE, 0, 0, 0, 0, 1), 1'b1,
            bridge_status(1, 0, 0, 1, 3000, 0, 3, 0, 0));
    // A huge elapsed time rounds the RPM down to zero; the next stamp has
    // wrapped past the top of the timer.
    add_row(make_word(CMD_RIGHT_PULSE, 0, 0, 0, 0, 32'hFFFF_FFFF), 1'b1,
            bridge_status(1, 0, 0, 1, 3000, 0, 3, 1, 0));
    add_row(make_word(CMD_RIGHT_PULSE, 0, 0, 0, 0, 2), 1'b0, '0);
    // A move with a target of zero stops that wheel at its first pulse.
    add_row(make_word(CMD_MOVE, -256, 255, 0, 32767, 0), 1'b0, '0);
    add_row(make_word(CMD_LEFT_PULSE, 0, 0, 0, 0, 100), 1'b0, '0);
    add_row(make_word(CMD_RIGHT_PULSE, 0, 0, 0, 0, 1000), 1'b0, '0);
    // Small targets: each wheel stops on reaching its count, and position
    // mode stays set after both have stopped.
    add_row(make_word(CMD_MOVE, -1, -256, 2, 1, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(make_word(CMD_LEFT_PULSE, 255, 255, 32767, 32767, 101), 1'b0, '0);
    add_row(make_word(CMD_LEFT_PULSE, 0, 0, 0, 0, 101), 1'b0, '0);
    add_row(make_word(CMD_LEFT_PULSE, 0, 0, 0, 0, 5000), 1'b0, '0);
    add_row(make_word(CMD_RIGHT_PULSE, 0, 0, 0, 0, 1001), 1'b0, '0);
    // A drive word leaves position mode; later pulses no longer stop a wheel.
    add_row(make_word(CMD_DRIVE, 255, 255, 32767, 32767, 32'hFFFF_FFFF), 1'b0, '0);
    add_row(make_word(CMD_LEFT_PULSE, -256, -256, 32767, 32767, 32'h8000_0000), 1'b0, '0);
    add_row(make_word(CMD_DRIVE, 0, -256, 0, 0, 0), 1'b0, '0);
    add_row(make_word(CMD_MOVE, 0, 0, 32767, 0, 32'h5555_AAAA), 1'b0, '0);
    add_row(make_word(CMD_RIGHT_PULSE, 0, 0, 0, 0, 32'h8000_0001), 1'b0, '0);
    add_row(make_word(CMD_DRIVE, -255, 128, 0, 0, 0), 1'b0, '0);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    idle_on = 1'b1;
    foreach (sweep_rows[i]) push_word(sweep_rows[i].word, sweep_rows[i].known,
                                      sweep_rows[i].want);

    // Back-to-back burst on the right wheel: it stops half way through on
    // reaching its target, and the later pulses keep counting.
    idle_on = 1'b0;
    push_word(make_word(CMD_MOVE, 0, 0, $urandom_range(0, 32767), BURST_TARGET, 0),
              1'b0, '0);
    now = $urandom;
    for (n = 0; n < BURST_PULSES; n++) begin
      now = now + 32'($urandom_range(0, 3));
      push_word(make_word(CMD_RIGHT_PULSE, 0, 0, 0, 0, now), 1'b0, '0);
    end

    // Random phases, each at its own pulses-per-rev setting: the extremes,
    // a zero register, random values and back to the reset value.
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        0:       ppr = 8'd1;
        1:       ppr = 8'd255;
        2:       ppr = 8'd0;
        5:       ppr = PPR_RESET;
        default: ppr = PPR_WIDTH'($urandom_range(1, 255));
      endcase
      settle_block();
      write_ppr(ppr);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if (n % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
        // The receiver holds off for a long stretch while words keep coming
        // with no gaps, so the queue fills and the input stalls.
        if (phase == 1 && n == 130) begin
          idle_on       = 1'b0;
          long_hold_req = 1'b1;
        end
        // The sender pauses until the block has handed back everything.
        if (phase == 3 && n == 100) settle_block();
        push_word(random_word(), 1'b0, '0);
      end
    end

    settle_block();
    if (fault_count == 0 && status_due.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
